### src/ptrmx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrmx_pkg
// shared types, sizes and codes of the persistent trie range max-xor core
// ----------------------------------------------------------------------------
package ptrmx_pkg;

    // key and store sizing
    localparam int KEY_BITS     = 15;
    localparam int MAX_ELEMENTS = 1024;

    // transaction field widths
    localparam int CMD_W    = 2;
    localparam int VALUE_W  = 15;
    localparam int INDEX_W  = 11;
    localparam int STATUS_W = 2;

    // derived storage sizes
    localparam int CNT_W      = $clog2(MAX_ELEMENTS + 1);
    localparam int NODE_DEPTH = MAX_ELEMENTS * (KEY_BITS + 1) + 1;
    localparam int NODE_AW    = $clog2(NODE_DEPTH);
    localparam int ROOT_DEPTH = MAX_ELEMENTS + 1;
    localparam int ROOT_AW    = $clog2(ROOT_DEPTH);
    localparam int NODE_W     = CNT_W + 2 * NODE_AW;
    localparam int LVL_W      = $clog2(KEY_BITS + 1);
    localparam int BIT_W      = $clog2(KEY_BITS);

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 2'd0,
        CMD_QUERY  = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD_RANGE = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_A_PREV,
        S_A_WR,
        S_Q_RNODE,
        S_Q_LOAD,
        S_Q_CHK,
        S_DONE
    } walk_state_t;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [VALUE_W-1:0] value;
        logic [INDEX_W-1:0] left_index;
        logic [INDEX_W-1:0] right_index;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  max_xor;
    } out_item_t;

    // one trie node: element count below it and its two child links
    typedef struct packed {
        logic [CNT_W-1:0]   cnt;
        logic [NODE_AW-1:0] kid1;
        logic [NODE_AW-1:0] kid0;
    } node_t;

    typedef struct packed {
        logic               we;
        logic [NODE_AW-1:0] waddr;
        node_t              wdata;
        logic [NODE_AW-1:0] raddr_a;
        logic [NODE_AW-1:0] raddr_b;
    } node_req_t;

    typedef struct packed {
        logic               we;
        logic [ROOT_AW-1:0] waddr;
        logic [NODE_AW-1:0] wdata;
        logic [ROOT_AW-1:0] raddr_a;
        logic [ROOT_AW-1:0] raddr_b;
    } root_req_t;

    typedef struct packed {
        logic      valid;
        out_item_t item;
    } walk_res_t;

    function automatic logic [NODE_AW-1:0] kid_of(input node_t n, input logic b);
        return b ? n.kid1 : n.kid0;
    endfunction

endpackage

### src/ptrmx_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrmx_ram
// generic ram, one write port and two registered read ports
// ----------------------------------------------------------------------------
module ptrmx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

### src/ptrmx_walk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrmx_walk
// command sequencer: path copy on append, two-version walk on query
// ----------------------------------------------------------------------------
module ptrmx_walk
    import ptrmx_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  in_item_t           item,
    output logic               idle,
    output node_req_t          node_req,
    input  logic [NODE_W-1:0]  node_rdata_a,
    input  logic [NODE_W-1:0]  node_rdata_b,
    output root_req_t          root_req,
    input  logic [NODE_AW-1:0] root_rdata_a,
    input  logic [NODE_AW-1:0] root_rdata_b,
    output walk_res_t          res,
    input  logic               res_take
);

    walk_state_t         state_reg, state_next;
    logic [LVL_W-1:0]    lvl_reg, lvl_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [KEY_BITS-1:0] xor_reg, xor_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [NODE_AW-1:0]  cur_reg, cur_next;
    logic [NODE_AW-1:0]  free_reg, free_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    node_t               lo_node_reg, lo_node_next;
    node_t               hi_node_reg, hi_node_next;
    logic                nz_a_reg, nz_b_reg, rz_a_reg, rz_b_reg;

    node_t               nd_a, nd_b;
    logic [NODE_AW-1:0]  root_a, root_b;
    logic [BIT_W-1:0]    bit_idx, nxt_idx;
    logic                key_bit, nxt_want;
    logic                bad_range;

    // address zero is the empty root and is never written: it reads as zero
    assign nd_a   = nz_a_reg ? node_t'('0) : node_t'(node_rdata_a);
    assign nd_b   = nz_b_reg ? node_t'('0) : node_t'(node_rdata_b);
    assign root_a = rz_a_reg ? '0 : root_rdata_a;
    assign root_b = rz_b_reg ? '0 : root_rdata_b;

    assign bit_idx  = BIT_W'(lvl_reg - LVL_W'(1));
    assign nxt_idx  = BIT_W'(lvl_reg - LVL_W'(2));
    assign key_bit  = key_reg[bit_idx];
    assign nxt_want = ~key_reg[nxt_idx];

    assign bad_range = (item.left_index == '0)
                    || ({1'b0, item.right_index} > (INDEX_W + 1)'(count_reg))
                    || (item.left_index > item.right_index);

    assign idle = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            free_reg  <= NODE_AW'(1);
            nz_a_reg  <= 1'b1;
            nz_b_reg  <= 1'b1;
            rz_a_reg  <= 1'b1;
            rz_b_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            free_reg  <= free_next;
            nz_a_reg  <= (node_req.raddr_a == '0);
            nz_b_reg  <= (node_req.raddr_b == '0);
            rz_a_reg  <= (root_req.raddr_a == '0);
            rz_b_reg  <= (root_req.raddr_b == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        lvl_reg     <= lvl_next;
        key_reg     <= key_next;
        xor_reg     <= xor_next;
        status_reg  <= status_next;
        cur_reg     <= cur_next;
        lo_node_reg <= lo_node_next;
        hi_node_reg <= hi_node_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        lvl_next     = lvl_reg;
        key_next     = key_reg;
        xor_next     = xor_reg;
        status_next  = status_reg;
        cur_next     = cur_reg;
        free_next    = free_reg;
        count_next   = count_reg;
        lo_node_next = lo_node_reg;
        hi_node_next = hi_node_reg;
        node_req     = '0;
        root_req     = '0;
        res          = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    key_next    = item.value[KEY_BITS-1:0];
                    xor_next    = '0;
                    status_next = ST_OK;
                    lvl_next    = LVL_W'(KEY_BITS);
                    state_next  = S_DONE;
                    case (item.cmd)
                        CMD_APPEND:
                        begin
                            if (count_reg == CNT_W'(MAX_ELEMENTS))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                // fetch previous root, record the new root
                                root_req.raddr_a = ROOT_AW'(count_reg);
                                root_req.we      = 1'b1;
                                root_req.waddr   = ROOT_AW'(count_reg + CNT_W'(1));
                                root_req.wdata   = free_reg;
                                cur_next         = free_reg;
                                free_next        = free_reg + NODE_AW'(1);
                                state_next       = S_A_PREV;
                            end
                        end
                        CMD_QUERY:
                        begin
                            if (bad_range)
                            begin
                                status_next = ST_BAD_RANGE;
                            end
                            else
                            begin
                                root_req.raddr_a = ROOT_AW'(item.left_index - INDEX_W'(1));
                                root_req.raddr_b = ROOT_AW'(item.right_index);
                                state_next       = S_Q_RNODE;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                            free_next  = NODE_AW'(1);
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end

            S_A_PREV:
            begin
                node_req.raddr_a = root_a;
                state_next       = S_A_WR;
            end

            S_A_WR:
            begin
                node_req.we          = 1'b1;
                node_req.waddr       = cur_reg;
                node_req.wdata.cnt   = nd_a.cnt + CNT_W'(1);
                if (lvl_reg != '0)
                begin
                    if (key_bit)
                    begin
                        node_req.wdata.kid1 = free_reg;
                        node_req.wdata.kid0 = nd_a.kid0;
                    end
                    else
                    begin
                        node_req.wdata.kid1 = nd_a.kid1;
                        node_req.wdata.kid0 = free_reg;
                    end
                    node_req.raddr_a = kid_of(nd_a, key_bit);
                    cur_next         = free_reg;
                    free_next        = free_reg + NODE_AW'(1);
                    lvl_next         = lvl_reg - LVL_W'(1);
                end
                else
                begin
                    // leaf: no children
                    node_req.wdata.kid1 = '0;
                    node_req.wdata.kid0 = '0;
                    count_next          = count_reg + CNT_W'(1);
                    state_next          = S_DONE;
                end
            end

            S_Q_RNODE:
            begin
                node_req.raddr_a = root_a;
                node_req.raddr_b = root_b;
                state_next       = S_Q_LOAD;
            end

            S_Q_LOAD:
            begin
                lo_node_next     = nd_a;
                hi_node_next     = nd_b;
                node_req.raddr_a = kid_of(nd_a, ~key_bit);
                node_req.raddr_b = kid_of(nd_b, ~key_bit);
                state_next       = S_Q_CHK;
            end

            S_Q_CHK:
            begin
                if (nd_b.cnt != nd_a.cnt)
                begin
                    // opposite branch holds an element of the range
                    xor_next[bit_idx] = 1'b1;
                    lo_node_next      = nd_a;
                    hi_node_next      = nd_b;
                    if (lvl_reg == LVL_W'(1))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        node_req.raddr_a = kid_of(nd_a, nxt_want);
                        node_req.raddr_b = kid_of(nd_b, nxt_want);
                        lvl_next         = lvl_reg - LVL_W'(1);
                    end
                end
                else if (lvl_reg == LVL_W'(1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    node_req.raddr_a = kid_of(lo_node_reg, key_bit);
                    node_req.raddr_b = kid_of(hi_node_reg, key_bit);
                    lvl_next         = lvl_reg - LVL_W'(1);
                    state_next       = S_Q_LOAD;
                end
            end

            S_DONE:
            begin
                res.valid        = 1'b1;
                res.item.status  = status_reg;
                res.item.max_xor = VALUE_W'(xor_reg);
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### src/persistent_trie_range_max_xor_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// persistent_trie_range_max_xor_core
// persistent binary trie over 15-bit keys answering range max-xor queries
// ----------------------------------------------------------------------------
// One command per request transaction, one response transaction per command.
// An append copies one root-to-leaf path of 16 nodes into fresh node-memory
// entries, writing one node per cycle. A query walks the two versions
// left_index-1 and right_index side by side, one dual-port node-memory read
// per trie level when the opposite branch holds an element and two when it
// does not (the last level always takes one). Clear, the unused command, a
// full store and a bad range go from idle straight to the response state.
// The pace
// is set by the registered read of the node memory, whose data steers the
// next read address. Node zero is the empty root and is never written; its
// reads are forced to zero, so no clearing pass runs after reset. A new
// request is taken as soon as the sequencer is idle, even while the previous
// response still waits in the output register.
// ----------------------------------------------------------------------------
module persistent_trie_range_max_xor_core
    import ptrmx_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  in_item_t  req_item,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output out_item_t rsp_item
);

    // memory request bundles from the sequencer
    node_req_t          node_req;
    root_req_t          root_req;
    logic [NODE_W-1:0]  node_rdata_a, node_rdata_b;
    logic [NODE_AW-1:0] root_rdata_a, root_rdata_b;

    walk_res_t          res;
    logic               walk_idle;
    logic               start;
    logic               res_take;

    logic               rsp_valid_reg, rsp_valid_next;
    out_item_t          rsp_item_reg, rsp_item_next;

    // request transaction accepted whenever the sequencer is idle
    assign req_ready = walk_idle;
    assign start     = req_valid && req_ready;

    // response moves into the output register when it is free or draining
    assign res_take  = res.valid && (!rsp_valid_reg || rsp_ready);

    // node memory: count plus two child links per entry
    ptrmx_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NODE_DEPTH)
    ) u_node_ram (
        .clk     (clk),
        .we      (node_req.we),
        .waddr   (node_req.waddr),
        .wdata   (node_req.wdata),
        .raddr_a (node_req.raddr_a),
        .raddr_b (node_req.raddr_b),
        .rdata_a (node_rdata_a),
        .rdata_b (node_rdata_b)
    );

    // root table: root node of each version
    ptrmx_ram #(
        .WIDTH (NODE_AW),
        .DEPTH (ROOT_DEPTH)
    ) u_root_ram (
        .clk     (clk),
        .we      (root_req.we),
        .waddr   (root_req.waddr),
        .wdata   (root_req.wdata),
        .raddr_a (root_req.raddr_a),
        .raddr_b (root_req.raddr_b),
        .rdata_a (root_rdata_a),
        .rdata_b (root_rdata_b)
    );

    // command sequencer
    ptrmx_walk u_walk (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .item         (req_item),
        .idle         (walk_idle),
        .node_req     (node_req),
        .node_rdata_a (node_rdata_a),
        .node_rdata_b (node_rdata_b),
        .root_req     (root_req),
        .root_rdata_a (root_rdata_a),
        .root_rdata_b (root_rdata_b),
        .res          (res),
        .res_take     (res_take)
    );

    // output register
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_item_next  = rsp_item_reg;
        if (res_take)
        begin
            rsp_valid_next = 1'b1;
            rsp_item_next  = res.item;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // response payload, held while waiting
    always_ff @(posedge clk)
    begin
        rsp_item_reg <= rsp_item_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

endmodule

### tb/tb_persistent_trie_range_max_xor_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_persistent_trie_range_max_xor_core
// self-checking bench for the persistent trie range max-xor core
// ----------------------------------------------------------------------------
// A shadow trie in the bench tracks every accepted request transaction and
// queues the response it should produce. Responses are compared field by
// field in order. A short directed table covers empty-store queries, key
// extremes, every bad-range form, clear and the unused command. Random
// traffic follows in three idle profiles, the last one clearing the store
// and appending until it is full, so that full-store appends and queries
// over the whole 1..1024 range are reached.
// ----------------------------------------------------------------------------
module tb_persistent_trie_range_max_xor_core;
    import ptrmx_pkg::*;

    // cmd encoding the core must ignore
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int WATCHDOG_LIMIT = 5000;  // cycles without any transaction
    localparam int SETTLE_CYCLES  = 40;    // longer than the slowest query
    localparam int MAX_PRINTED    = 40;
    localparam int PEND_DEPTH     = 16;    // responses owed at most
    localparam int STIM_DEPTH     = 32;    // rows of the directed table

    typedef struct {
        in_item_t  item;
        bit        known;  // response typed into the table
        out_item_t want;
    } stim_row_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    in_item_t  req_item  = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    out_item_t rsp_item;

    persistent_trie_range_max_xor_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_item  (rsp_item)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------------
    // shadow trie: per-node element count and child links, one root per
    // version, version 0 is the empty root at node 0
    // ------------------------------------------------------------------------
    int unsigned node_count [NODE_DEPTH];
    int unsigned node_kid0  [NODE_DEPTH];
    int unsigned node_kid1  [NODE_DEPTH];
    int unsigned version_root [ROOT_DEPTH];
    int unsigned elem_total;
    int unsigned free_node;

    // responses still owed by the core, kept as a ring
    out_item_t   pending_rsp [PEND_DEPTH];
    int          pend_wr  = 0;
    int          pend_rd  = 0;
    int          pend_cnt = 0;

    stim_row_t   stim_table [STIM_DEPTH];
    int          stim_rows = 0;
    int          row_idx;

    out_item_t   model_rsp;
    out_item_t   oldest;
    bit          typed_known = 1'b0;
    out_item_t   typed_want  = '0;
    int          err_count    = 0;
    int          stall_cycles = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    logic [VALUE_W-1:0] last_key = '0;
    int          fill_tail;

    function automatic int unsigned child_of(int unsigned node, bit b);
        return b ? node_kid1[node] : node_kid0[node];
    endfunction

    function automatic void trie_wipe();
        int i;
        for (i = 0; i < NODE_DEPTH; i++)
        begin
            node_count[i] = 0;
            node_kid0[i]  = 0;
            node_kid1[i]  = 0;
        end
        for (i = 0; i < ROOT_DEPTH; i++)
            version_root[i] = 0;
        elem_total = 0;
        free_node  = 1;
    endfunction

    // copy one root-to-leaf path, bumping counts, sharing the untaken side
    function automatic status_t trie_insert(logic [VALUE_W-1:0] key);
        int unsigned prev, cur, nxt;
        int          lvl;
        bit          b;
        if (elem_total >= MAX_ELEMENTS)
            return ST_FULL;
        prev = version_root[elem_total];
        cur  = free_node;
        free_node++;
        version_root[elem_total + 1] = cur;
        for (lvl = KEY_BITS - 1; lvl >= 0; lvl--)
        begin
            b   = key[lvl];
            nxt = free_node;
            free_node++;
            node_count[cur] = node_count[prev] + 1;
            if (b)
            begin
                node_kid1[cur] = nxt;
                node_kid0[cur] = node_kid0[prev];
            end
            else
            begin
                node_kid0[cur] = nxt;
                node_kid1[cur] = node_kid1[prev];
            end
            prev = child_of(prev, b);
            cur  = nxt;
        end
        node_count[cur] = node_count[prev] + 1;
        node_kid0[cur]  = 0;
        node_kid1[cur]  = 0;
        elem_total++;
        return ST_OK;
    endfunction

    // walk two versions together, prefer the opposite bit when it holds
    // at least one element inside the range
    function automatic logic [VALUE_W-1:0] trie_best_xor(logic [VALUE_W-1:0] key,
                                                       int unsigned lo_ver,
                                                       int unsigned hi_ver);
        int unsigned        lo, hi;
        int                 lvl;
        bit                 want;
        logic [VALUE_W-1:0] best;
        lo   = version_root[lo_ver];
        hi   = version_root[hi_ver];
        best = '0;
        for (lvl = KEY_BITS - 1; lvl >= 0; lvl--)
        begin
            want = ~key[lvl];
            if (node_count[child_of(hi, want)] != node_count[child_of(lo, want)])
            begin
                best[lvl] = 1'b1;
                hi = child_of(hi, want);
                lo = child_of(lo, want);
            end
            else
            begin
                hi = child_of(hi, !want);
                lo = child_of(lo, !want);
            end
        end
        return best;
    endfunction

    // advance the shadow trie by one command and give its response
    function automatic out_item_t trie_apply(in_item_t it);
        out_item_t r;
        r = '0;
        case (it.cmd)
            CMD_APPEND:
                r.status = trie_insert(it.value);
            CMD_QUERY:
                if (it.left_index == 0 || it.right_index > elem_total ||
                    it.left_index > it.right_index)
                    r.status = ST_BAD_RANGE;
                else
                    r.max_xor = trie_best_xor(it.value, it.left_index - 1,
                                              it.right_index);
            CMD_CLEAR:
            begin
                elem_total      = 0;
                free_node       = 1;
                version_root[0] = 0;
            end
            default:
                ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (err_count < MAX_PRINTED)
            $display("mismatch at %0t ns: %s", $time, msg);
        err_count++;
    endtask

    // ------------------------------------------------------------------------
    // monitor: predict on every accepted request, check every accepted
    // response against the oldest prediction, and watch for a hang
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
            begin
                model_rsp = trie_apply(req_item);
                if (pend_cnt == PEND_DEPTH)
                    report_mismatch("too many responses outstanding");
                else
                begin
                    pending_rsp[pend_wr] = typed_known ? typed_want : model_rsp;
                    pend_wr = (pend_wr + 1) % PEND_DEPTH;
                    pend_cnt++;
                end
            end
            if (rsp_valid && rsp_ready)
            begin
                if (pend_cnt == 0)
                    report_mismatch($sformatf("unexpected response status %0d max_xor 0x%0h",
                                              rsp_item.status, rsp_item.max_xor));
                else
                begin
                    oldest  = pending_rsp[pend_rd];
                    pend_rd = (pend_rd + 1) % PEND_DEPTH;
                    pend_cnt--;
                    if (rsp_item.status !== oldest.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  rsp_item.status, oldest.status));
                    if (rsp_item.max_xor !== oldest.max_xor)
                        report_mismatch($sformatf("max_xor got 0x%0h want 0x%0h",
                                                  rsp_item.max_xor, oldest.max_xor));
                end
            end
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // response side back-pressure, redrawn every cycle
    always @(negedge clk)
        rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------

    // random gap, then hold the transaction until the core takes it
    task automatic send_item(input in_item_t it, input bit known, input out_item_t want);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        req_item    = it;
        typed_known = known;
        typed_want  = want;
        req_valid   = 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    // stop sending until the core has answered everything
    task automatic drain_all();
        @(negedge clk);
        req_valid = 1'b0;
        while (pend_cnt != 0)
            @(negedge clk);
    endtask

    function automatic void add_row(logic [CMD_W-1:0] cmd, int unsigned value,
                                    int unsigned left, int unsigned right,
                                    bit known, status_t st, int unsigned mx);
        stim_row_t row;
        row.item.cmd         = cmd;
        row.item.value       = VALUE_W'(value);
        row.item.left_index  = INDEX_W'(left);
        row.item.right_index = INDEX_W'(right);
        row.known            = known;
        row.want.status      = st;
        row.want.max_xor     = VALUE_W'(mx);
        if (stim_rows < STIM_DEPTH)
        begin
            stim_table[stim_rows] = row;
            stim_rows++;
        end
    endfunction

    // mostly well-formed appends and in-range queries, some broken ranges,
    // rare clears and unused commands; keys often sit close to the last one
    // so that paths share long prefixes
    function automatic in_item_t gen_item(int append_pm, int clear_pm);
        in_item_t    it;
        int unsigned pick;
        int unsigned hi_r;
        it   = '0;
        pick = $urandom_range(0, 999);
        it.value       = ($urandom_range(0, 3) == 0)
                         ? (last_key ^ VALUE_W'($urandom_range(0, 63)))
                         : VALUE_W'($urandom_range(0, 32767));
        it.left_index  = INDEX_W'($urandom_range(0, 1024));
        it.right_index = INDEX_W'($urandom_range(0, 1024));
        if (pick < clear_pm)
            it.cmd = CMD_CLEAR;
        else if (pick < clear_pm + 10)
            it.cmd = CMD_UNUSED;
        else if (pick < clear_pm + 10 + append_pm)
        begin
            it.cmd   = CMD_APPEND;
            last_key = it.value;
        end
        else
        begin
            it.cmd = CMD_QUERY;
            if (elem_total > 0 && $urandom_range(0, 9) < 8)
            begin
                hi_r = ($urandom_range(0, 3) == 0) ? elem_total
                                                   : $urandom_range(1, elem_total);
                it.right_index = INDEX_W'(hi_r);
                it.left_index  = ($urandom_range(0, 3) == 0)
                                 ? INDEX_W'(1) : INDEX_W'($urandom_range(1, hi_r));
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0:
                        it.left_index = '0;
                    1:
                        if (elem_total < MAX_ELEMENTS)
                        begin
                            hi_r = $urandom_range(elem_total + 1, 1024);
                            it.right_index = INDEX_W'(hi_r);
                            it.left_index  = INDEX_W'($urandom_range(1, hi_r));
                        end
                        else
                            it.left_index = '0;
                    default:
                    begin
                        hi_r = $urandom_range(1, 1023);
                        it.right_index = INDEX_W'(hi_r);
                        it.left_index  = INDEX_W'($urandom_range(hi_r + 1, 1024));
                    end
                endcase
            end
        end
        return it;
    endfunction

    task automatic run_random(input int count, input int append_pm, input int clear_pm);
        int i;
        for (i = 0; i < count; i++)
        begin
            send_item(gen_item(append_pm, clear_pm), 1'b0, '0);
            if ($urandom_range(0, 99) == 0)
                drain_all();
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        trie_wipe();
        send_idle_pct = 34;
        recv_idle_pct = 61;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table: typed responses where obvious, shadow trie elsewhere
        add_row(CMD_QUERY,  0,      1,    1,    1, ST_BAD_RANGE, 0);  // empty store
        add_row(CMD_APPEND, 0,      0,    0,    1, ST_OK,        0);
        add_row(CMD_APPEND, 32767,  0,    0,    1, ST_OK,        0);
        add_row(CMD_QUERY,  0,      1,    2,    0, ST_OK,        0);
        add_row(CMD_QUERY,  32767,  1,    2,    0, ST_OK,        0);
        add_row(CMD_QUERY,  32767,  2,    2,    0, ST_OK,        0);
        add_row(CMD_QUERY,  5,      0,    1,    1, ST_BAD_RANGE, 0);  // left zero
        add_row(CMD_QUERY,  5,      2,    1,    1, ST_BAD_RANGE, 0);  // left past right
        add_row(CMD_QUERY,  5,      1,    3,    1, ST_BAD_RANGE, 0);  // right past count
        add_row(CMD_UNUSED, 32767,  1024, 1024, 1, ST_OK,        0);
        add_row(CMD_APPEND, 'h5555, 0,    0,    1, ST_OK,        0);
        add_row(CMD_APPEND, 'h2aaa, 0,    0,    1, ST_OK,        0);
        add_row(CMD_QUERY,  'h5555, 3,    4,    0, ST_OK,        0);
        add_row(CMD_QUERY,  'h1234, 2,    2,    0, ST_OK,        0);
        add_row(CMD_QUERY,  'h7fff, 1,    4,    0, ST_OK,        0);
        add_row(CMD_QUERY,  0,      1024, 1024, 1, ST_BAD_RANGE, 0);
        add_row(CMD_CLEAR,  'h7fff, 1024, 1024, 1, ST_OK,        0);
        add_row(CMD_QUERY,  0,      1,    1,    1, ST_BAD_RANGE, 0);  // cleared store
        add_row(CMD_APPEND, 1,      0,    0,    1, ST_OK,        0);
        add_row(CMD_QUERY,  0,      1,    1,    0, ST_OK,        0);
        add_row(CMD_APPEND, 'h4000, 0,    0,    1, ST_OK,        0);
        add_row(CMD_QUERY,  'h3fff, 1,    2,    0, ST_OK,        0);
        add_row(CMD_QUERY,  'h4001, 1,    2,    0, ST_OK,        0);
        for (row_idx = 0; row_idx < stim_rows; row_idx++)
            send_item(stim_table[row_idx].item, stim_table[row_idx].known,
                      stim_table[row_idx].want);

        run_random(40, 550, 15);
        drain_all();

        // swapped idle profile
        send_idle_pct = 61;
        recv_idle_pct = 34;
        run_random(40, 550, 15);
        drain_all();

        // full speed: start empty and append until the store is full, then
        // keep going so that full-store appends and wide queries are hit
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_item('{cmd: CMD_CLEAR, value: '0, left_index: '0, right_index: '0},
                  1'b1, '{status: ST_OK, max_xor: '0});
        fill_tail = 0;
        while (fill_tail < 40)
        begin
            send_item(gen_item(940, 0), 1'b0, '0);
            if (elem_total == MAX_ELEMENTS)
                fill_tail++;
        end

        drain_all();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### persistent_trie_range_max_xor_core.f
src/ptrmx_pkg.sv
src/ptrmx_ram.sv
src/ptrmx_walk.sv
src/persistent_trie_range_max_xor_core.sv
tb/tb_persistent_trie_range_max_xor_core.sv
